FILE: rtl/tadt_pkg.sv
package tadt_pkg;

   // Angles are in 1/16 degree.
   localparam int FULL_TURN = 5760;
   localparam int HALF_TURN = 2880;

   // Bias added before the modulo reduction so that the dividend is never negative.
   localparam int TURN_BIAS = 92 * FULL_TURN;
   localparam int LOAD_BIAS = 2 * FULL_TURN;

   localparam int TABLE_SIZE_DEFAULT = 16;

   localparam int ENTRY_W     = 13;
   localparam int ANGLE_W     = 12;
   localparam int TIME_W      = 16;
   localparam int STEP_W      = 8;
   localparam int TARGET_W    = 20;
   localparam int DIVIDEND_W  = 21;
   localparam int QUOTIENT_W  = 8;
   localparam int PRODUCT_W   = ANGLE_W + STEP_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_IGNORE_ENABLE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IGNORE_DISTANCE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_MS         = 2'd2;

   // Configuration reset values.
   localparam logic               IGNORE_ENABLE_RESET   = 1'b1;
   localparam logic [ANGLE_W-1:0] IGNORE_DISTANCE_RESET = 12'd160;
   localparam logic [STEP_W-1:0]  STEP_MS_RESET         = 8'd50;

   // Item actions.
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_TURN = 1'b1;

   // Turn directions.
   localparam logic [1:0] DIR_NONE  = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;

endpackage

FILE: rtl/tadt_div.sv
module tadt_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [tadt_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [tadt_pkg::ENTRY_W-1:0]    divisor,
   output logic                             done,
   output logic [tadt_pkg::QUOTIENT_W-1:0] quotient,
   output logic [tadt_pkg::ENTRY_W-1:0]    remainder
);

   localparam int CNT_W = $clog2(tadt_pkg::QUOTIENT_W);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic [tadt_pkg::DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [tadt_pkg::QUOTIENT_W-1:0] quo_ff, quo_in;
   logic [tadt_pkg::ENTRY_W-1:0]    dsr_ff, dsr_in;
   logic [tadt_pkg::DIVIDEND_W-1:0] shifted;
   logic [tadt_pkg::DIVIDEND_W:0]   diff;
   logic                             take;

   // One quotient bit per cycle, most significant first.
   always_comb begin
      shifted = tadt_pkg::DIVIDEND_W'(dsr_ff) << cnt_ff;
      diff    = {1'b0, rem_ff} - {1'b0, shifted};
      take    = !diff[tadt_pkg::DIVIDEND_W];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(tadt_pkg::QUOTIENT_W - 1);
         rem_in  = dividend;
         quo_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (take) begin
            rem_in = diff[tadt_pkg::DIVIDEND_W-1:0];
         end
         quo_in = {quo_ff[tadt_pkg::QUOTIENT_W-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[tadt_pkg::ENTRY_W-1:0];

endmodule

FILE: rtl/tadt_smul.sv
module tadt_smul (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [tadt_pkg::STEP_W-1:0]    multiplier,
   input  logic [tadt_pkg::ANGLE_W-1:0]   mcand_a,
   input  logic [tadt_pkg::TIME_W-1:0]    mcand_b,
   input  logic [tadt_pkg::TIME_W-1:0]    mcand_c,
   output logic                            done,
   output logic [tadt_pkg::PRODUCT_W-1:0] prod_a,
   output logic [tadt_pkg::TIME_W-1:0]    prod_b,
   output logic [tadt_pkg::TIME_W-1:0]    prod_c
);

   localparam int CNT_W = $clog2(tadt_pkg::STEP_W);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [tadt_pkg::STEP_W-1:0]    mpl_ff, mpl_in;
   logic [tadt_pkg::PRODUCT_W-1:0] mca_ff, mca_in, acc_a_ff, acc_a_in;
   logic [tadt_pkg::TIME_W-1:0]    mcb_ff, mcb_in, acc_b_ff, acc_b_in;
   logic [tadt_pkg::TIME_W-1:0]    mcc_ff, mcc_in, acc_c_ff, acc_c_in;

   // Shift and add, one multiplier bit per cycle, least significant first.
   // The three products share the multiplier bits.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mpl_in   = mpl_ff;
      mca_in   = mca_ff;
      mcb_in   = mcb_ff;
      mcc_in   = mcc_ff;
      acc_a_in = acc_a_ff;
      acc_b_in = acc_b_ff;
      acc_c_in = acc_c_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(tadt_pkg::STEP_W - 1);
         mpl_in   = multiplier;
         mca_in   = tadt_pkg::PRODUCT_W'(mcand_a);
         mcb_in   = mcand_b;
         mcc_in   = mcand_c;
         acc_a_in = '0;
         acc_b_in = '0;
         acc_c_in = '0;
      end else if (busy_ff) begin
         if (mpl_ff[0]) begin
            acc_a_in = acc_a_ff + mca_ff;
            acc_b_in = acc_b_ff + mcb_ff;
            acc_c_in = acc_c_ff + mcc_ff;
         end
         mpl_in = mpl_ff >> 1;
         mca_in = mca_ff << 1;
         mcb_in = mcb_ff << 1;
         mcc_in = mcc_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mpl_ff   <= mpl_in;
      mca_ff   <= mca_in;
      mcb_ff   <= mcb_in;
      mcc_ff   <= mcc_in;
      acc_a_ff <= acc_a_in;
      acc_b_ff <= acc_b_in;
      acc_c_ff <= acc_c_in;
   end

   assign done   = done_ff;
   assign prod_a = acc_a_ff;
   assign prod_b = acc_b_ff;
   assign prod_c = acc_c_ff;

endmodule

FILE: rtl/tadt_table.sv
module tadt_table #(
   parameter int TABLE_SIZE = tadt_pkg::TABLE_SIZE_DEFAULT,
   parameter int IDX_W      = $clog2(TABLE_SIZE)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [IDX_W-1:0]              wr_addr,
   input  logic [tadt_pkg::ENTRY_W-1:0] wr_data,
   input  logic [IDX_W-1:0]              rd_addr,
   output logic [tadt_pkg::ENTRY_W-1:0] rd_data
);

   logic [tadt_pkg::ENTRY_W-1:0] mem [TABLE_SIZE];
   logic [TABLE_SIZE-1:0]        valid_ff;
   logic [tadt_pkg::ENTRY_W-1:0] rd_data_ff;
   logic                         rd_ok_ff;

   // An entry that was never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_ok_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ok_ff ? rd_data_ff : '0;

endmodule

FILE: rtl/turn_angle_to_drive_time.sv
// Turn angle to drive time. A load item (action 0) stores one calibration
// entry, the heading change wrapped into one full turn, unless it aims at
// entry zero or past the table; a turn item (action 1) reduces the target
// angle, picks a direction, applies the optional dead zone and interpolates
// the calibration table to a drive time in ms. An item is accepted when start
// is high and busy is low, and every item gives exactly one result on the
// rsp_ ports, marked by rsp_strobe for one cycle. The receiver cannot stall:
// the result is gone after that cycle, so it must be captured when the strobe
// is seen. A load item keeps busy high only for its pass through the shared
// bit-serial divider that wraps the heading difference. A turn item keeps busy
// high through the divider for the modulo reduction, whose remainder is also
// folded into a half turn, the table search (a first read through the
// registered read port of the calibration memory, then one entry per cycle up
// to the last entry at most), the shift-and-add multiplier and a final pass
// through the divider. When no entry lies above the angle the final divide is
// skipped. A turn inside the dead zone skips the table search and takes as
// long as a load. The result strobe comes in the same cycle that busy falls,
// and the next item may be accepted in that same cycle. No clearing pass is
// needed after reset; the table comes up as all zeros. Configuration
// registers may only be written while no item is in flight.
module turn_angle_to_drive_time #(
   parameter int TABLE_SIZE = tadt_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_start,
   output logic                                  busy,
   input  logic                                  req_action,
   input  logic [3:0]                            req_entry_index,
   input  logic [tadt_pkg::ENTRY_W-1:0]         req_heading_before,
   input  logic [tadt_pkg::ENTRY_W-1:0]         req_heading_after,
   input  logic signed [tadt_pkg::TARGET_W-1:0] req_target_angle,

   output logic                                  rsp_strobe,
   output logic [1:0]                            rsp_direction,
   output logic [tadt_pkg::TIME_W-1:0]          rsp_turn_time_ms,
   output logic [tadt_pkg::ANGLE_W-1:0]         rsp_reduced_angle,
   output logic                                  rsp_turn_issued,

   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tadt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tadt_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SCAN,
      ST_MUL,
      ST_DIV
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic                             ignore_enable_ff, ignore_enable_in;
   logic [tadt_pkg::ANGLE_W-1:0]    ignore_distance_ff, ignore_distance_in;
   logic [tadt_pkg::STEP_W-1:0]     step_ms_ff, step_ms_in;

   // Item in flight.
   logic                             action_ff, action_in;
   logic [3:0]                       index_ff, index_in;
   logic [tadt_pkg::ANGLE_W-1:0]    angle_ff, angle_in;
   logic [1:0]                       dir_ff, dir_in;

   // Table search.
   logic [IDX_W-1:0]                 scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]                 rd_idx_ff, rd_idx_in;
   logic                             pend_ff, pend_in;
   logic [tadt_pkg::ENTRY_W-1:0]    prev_ff, prev_in;
   logic [tadt_pkg::ENTRY_W-1:0]    span_ff, span_in;
   logic                             miss_ff, miss_in;

   // Result registers.
   logic                             rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]                       rsp_direction_ff, rsp_direction_in;
   logic [tadt_pkg::TIME_W-1:0]     rsp_time_ff, rsp_time_in;
   logic [tadt_pkg::ANGLE_W-1:0]    rsp_angle_ff, rsp_angle_in;
   logic                             rsp_issued_ff, rsp_issued_in;

   // Shared divider.
   logic                             div_start;
   logic [tadt_pkg::DIVIDEND_W-1:0] div_dividend;
   logic [tadt_pkg::ENTRY_W-1:0]    div_divisor;
   logic                             div_done;
   logic [tadt_pkg::QUOTIENT_W-1:0] div_quotient;
   logic [tadt_pkg::ENTRY_W-1:0]    div_remainder;

   // Serial multiplier.
   logic                             mul_start;
   logic [tadt_pkg::ANGLE_W-1:0]    mul_frac;
   logic [tadt_pkg::TIME_W-1:0]     mul_base;
   logic                             mul_done;
   logic [tadt_pkg::PRODUCT_W-1:0]  mul_prod_frac;
   logic [tadt_pkg::TIME_W-1:0]     mul_prod_base;
   logic [tadt_pkg::TIME_W-1:0]     mul_prod_full;

   // Calibration memory.
   logic                             tbl_wr_en;
   logic [tadt_pkg::ENTRY_W-1:0]    tbl_rd_data;

   logic [tadt_pkg::DIVIDEND_W-1:0] turn_dividend;
   logic [tadt_pkg::DIVIDEND_W-1:0] load_dividend;
   logic [tadt_pkg::ENTRY_W-1:0]    fold_diff;
   logic [tadt_pkg::ANGLE_W-1:0]    fold_angle;
   logic [1:0]                       fold_dir;
   logic [tadt_pkg::TIME_W-1:0]     time_sum;
   logic                             index_ok;

   // Both dividends are biased by whole turns so that they are never negative;
   // the remainder modulo a full turn is unchanged by the bias.
   assign turn_dividend = {req_target_angle[tadt_pkg::TARGET_W-1], req_target_angle}
                        + tadt_pkg::DIVIDEND_W'(tadt_pkg::TURN_BIAS);
   assign load_dividend = tadt_pkg::DIVIDEND_W'(req_heading_after)
                        + tadt_pkg::DIVIDEND_W'(tadt_pkg::LOAD_BIAS)
                        - tadt_pkg::DIVIDEND_W'(req_heading_before);

   // Entry zero is fixed at zero, and indexes past the table are dropped.
   assign index_ok = (index_ff != '0) && (32'(index_ff) < TABLE_SIZE);

   // Fold the reduced angle into a half turn and pick the direction.
   assign fold_diff  = tadt_pkg::ENTRY_W'(tadt_pkg::FULL_TURN) - div_remainder;
   assign fold_angle = (div_remainder < tadt_pkg::ENTRY_W'(tadt_pkg::HALF_TURN))
                     ? div_remainder[tadt_pkg::ANGLE_W-1:0]
                     : fold_diff[tadt_pkg::ANGLE_W-1:0];
   assign fold_dir   = (div_remainder < tadt_pkg::ENTRY_W'(tadt_pkg::HALF_TURN))
                     ? tadt_pkg::DIR_RIGHT : tadt_pkg::DIR_LEFT;

   // Whole steps below the bracketing entry plus the interpolated fraction.
   assign time_sum = mul_prod_base + tadt_pkg::TIME_W'(div_quotient);

   always_comb begin
      state_in           = state_ff;
      ignore_enable_in   = ignore_enable_ff;
      ignore_distance_in = ignore_distance_ff;
      step_ms_in         = step_ms_ff;
      action_in          = action_ff;
      index_in           = index_ff;
      angle_in           = angle_ff;
      dir_in             = dir_ff;
      scan_idx_in        = scan_idx_ff;
      rd_idx_in          = rd_idx_ff;
      pend_in            = pend_ff;
      prev_in            = prev_ff;
      span_in            = span_ff;
      miss_in            = miss_ff;
      rsp_strobe_in      = 1'b0;
      rsp_direction_in   = rsp_direction_ff;
      rsp_time_in        = rsp_time_ff;
      rsp_angle_in       = rsp_angle_ff;
      rsp_issued_in      = rsp_issued_ff;

      div_start    = 1'b0;
      div_dividend = (req_action == tadt_pkg::ACT_TURN) ? turn_dividend : load_dividend;
      div_divisor  = tadt_pkg::ENTRY_W'(tadt_pkg::FULL_TURN);
      mul_start    = 1'b0;
      mul_frac     = '0;
      mul_base     = '0;
      tbl_wr_en    = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            tadt_pkg::CSR_IGNORE_ENABLE:   ignore_enable_in   = csr_data[0];
            tadt_pkg::CSR_IGNORE_DISTANCE: ignore_distance_in = csr_data[tadt_pkg::ANGLE_W-1:0];
            tadt_pkg::CSR_STEP_MS:         step_ms_in         = csr_data[tadt_pkg::STEP_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_start) begin
               action_in = req_action;
               index_in  = req_entry_index;
               div_start = 1'b1;
               state_in  = ST_REDUCE;
            end
         end

         ST_REDUCE: begin
            if (div_done) begin
               rsp_direction_in = tadt_pkg::DIR_NONE;
               rsp_time_in      = '0;
               rsp_angle_in     = '0;
               rsp_issued_in    = 1'b0;
               if (action_ff == tadt_pkg::ACT_LOAD) begin
                  tbl_wr_en     = index_ok;
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end else if (ignore_enable_ff && (fold_angle < ignore_distance_ff)) begin
                  // Dead zone: no turn.
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  angle_in    = fold_angle;
                  dir_in      = fold_dir;
                  scan_idx_in = IDX_W'(1);
                  pend_in     = 1'b0;
                  prev_in     = '0;
                  state_in    = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // The read issued last cycle returns now; a new one goes out each cycle.
            scan_idx_in = scan_idx_ff + 1'b1;
            rd_idx_in   = scan_idx_ff;
            pend_in     = 1'b1;
            if (pend_ff) begin
               if (tadt_pkg::ENTRY_W'(angle_ff) < tbl_rd_data) begin
                  // First entry above the angle: interpolate between it and the last one.
                  span_in   = tbl_rd_data - prev_ff;
                  miss_in   = 1'b0;
                  mul_frac  = tadt_pkg::ANGLE_W'(tadt_pkg::ENTRY_W'(angle_ff) - prev_ff);
                  mul_base  = tadt_pkg::TIME_W'(rd_idx_ff) - 1'b1;
                  mul_start = 1'b1;
                  state_in  = ST_MUL;
               end else begin
                  prev_in = tbl_rd_data;
                  if (rd_idx_ff == LAST_IDX) begin
                     miss_in   = 1'b1;
                     mul_start = 1'b1;
                     state_in  = ST_MUL;
                  end
               end
            end
         end

         ST_MUL: begin
            if (mul_done) begin
               if (miss_ff) begin
                  // No entry above the angle: a full table of steps.
                  rsp_direction_in = dir_ff;
                  rsp_time_in      = mul_prod_full;
                  rsp_angle_in     = angle_ff;
                  rsp_issued_in    = 1'b1;
                  rsp_strobe_in    = 1'b1;
                  state_in         = ST_IDLE;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = tadt_pkg::DIVIDEND_W'(mul_prod_frac);
                  div_divisor  = span_ff;
                  state_in     = ST_DIV;
               end
            end
         end

         ST_DIV: begin
            if (div_done) begin
               rsp_direction_in = dir_ff;
               rsp_time_in      = (time_sum == '0) ? mul_prod_full : time_sum;
               rsp_angle_in     = angle_ff;
               rsp_issued_in    = 1'b1;
               rsp_strobe_in    = 1'b1;
               state_in         = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         ignore_enable_ff   <= tadt_pkg::IGNORE_ENABLE_RESET;
         ignore_distance_ff <= tadt_pkg::IGNORE_DISTANCE_RESET;
         step_ms_ff         <= tadt_pkg::STEP_MS_RESET;
         pend_ff            <= 1'b0;
         miss_ff            <= 1'b0;
         rsp_strobe_ff      <= 1'b0;
      end else begin
         state_ff           <= state_in;
         ignore_enable_ff   <= ignore_enable_in;
         ignore_distance_ff <= ignore_distance_in;
         step_ms_ff         <= step_ms_in;
         pend_ff            <= pend_in;
         miss_ff            <= miss_in;
         rsp_strobe_ff      <= rsp_strobe_in;
         action_ff          <= action_in;
         index_ff           <= index_in;
         angle_ff           <= angle_in;
         dir_ff             <= dir_in;
         scan_idx_ff        <= scan_idx_in;
         rd_idx_ff          <= rd_idx_in;
         prev_ff            <= prev_in;
         span_ff            <= span_in;
         rsp_direction_ff   <= rsp_direction_in;
         rsp_time_ff        <= rsp_time_in;
         rsp_angle_ff       <= rsp_angle_in;
         rsp_issued_ff      <= rsp_issued_in;
      end
   end

   tadt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   tadt_smul u_smul (
      .clock      (clock),
      .reset      (reset),
      .start      (mul_start),
      .multiplier (step_ms_ff),
      .mcand_a    (mul_frac),
      .mcand_b    (mul_base),
      .mcand_c    (tadt_pkg::TIME_W'(TABLE_SIZE)),
      .done       (mul_done),
      .prod_a     (mul_prod_frac),
      .prod_b     (mul_prod_base),
      .prod_c     (mul_prod_full)
   );

   tadt_table #(
      .TABLE_SIZE (TABLE_SIZE),
      .IDX_W      (IDX_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tbl_wr_en),
      .wr_addr (IDX_W'(index_ff)),
      .wr_data (div_remainder),
      .rd_addr (scan_idx_ff),
      .rd_data (tbl_rd_data)
   );

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_direction     = rsp_direction_ff;
   assign rsp_turn_time_ms  = rsp_time_ff;
   assign rsp_reduced_angle = rsp_angle_ff;
   assign rsp_turn_issued   = rsp_issued_ff;

endmodule

FILE: tb/turn_time_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and register ports of the turn time block,
// keeps its own copy of the calibration table and settings, and compares each
// result against the oldest awaited one.
module turn_time_checker
   import tadt_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_start,
   input  logic                       busy,
   input  logic                       req_action,
   input  logic [3:0]                 req_entry_index,
   input  logic [ENTRY_W-1:0]         req_heading_before,
   input  logic [ENTRY_W-1:0]         req_heading_after,
   input  logic signed [TARGET_W-1:0] req_target_angle,
   input  logic                       rsp_strobe,
   input  logic [1:0]                 rsp_direction,
   input  logic [TIME_W-1:0]          rsp_turn_time_ms,
   input  logic [ANGLE_W-1:0]         rsp_reduced_angle,
   input  logic                       rsp_turn_issued,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   output int                         pending_items,
   output int                         fail_count
);

   typedef struct packed {
      logic [1:0]         direction;
      logic [TIME_W-1:0]  turn_time_ms;
      logic [ANGLE_W-1:0] reduced_angle;
      logic               turn_issued;
   } turn_result_type;

   logic [ENTRY_W-1:0] cal_table [TABLE_SIZE];
   logic               dz_enable;
   logic [ANGLE_W-1:0] dz_width;
   logic [STEP_W-1:0]  step_ms_cfg;
   turn_result_type    awaited_q [$];
   int                 fails = 0;

   // Reduces any angle into one full turn, never negative.
   function automatic int wrap_turn(int value);
      int r;
      r = value % FULL_TURN;
      if (r < 0) begin
         r += FULL_TURN;
      end
      return r;
   endfunction

   // Piecewise linear lookup of the step count, scaled to milliseconds.
   function automatic logic [TIME_W-1:0] interpolate_time(int angle);
      longint span, num, t;
      int     hi, lo, i;
      bit     found;
      t = 0;
      found = 0;
      for (i = 1; i < TABLE_SIZE && !found; i++) begin
         hi = int'(cal_table[i]);
         if (angle < hi) begin
            found = 1;
            lo = int'(cal_table[i-1]);
            span = hi - lo;
            num = (longint'(i - 1) * span + (angle - lo)) * longint'(step_ms_cfg);
            if (span != 0) begin
               t = num / span;
            end
         end
      end
      if (t == 0) begin
         t = longint'(TABLE_SIZE) * longint'(step_ms_cfg);
      end
      if (t > 65535) begin
         t = 65535;
      end
      return TIME_W'(t);
   endfunction

   function automatic turn_result_type predict_turn(logic signed [TARGET_W-1:0] target);
      turn_result_type r;
      int              a;
      logic [1:0]      dir;
      r = '0;
      a = wrap_turn(int'(target));
      if (a < HALF_TURN) begin
         dir = DIR_RIGHT;
      end else begin
         a = FULL_TURN - a;
         dir = DIR_LEFT;
      end
      if (!(dz_enable && a < int'(dz_width))) begin
         r.direction = dir;
         r.reduced_angle = ANGLE_W'(a);
         r.turn_time_ms = interpolate_time(a);
         r.turn_issued = 1'b1;
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      turn_result_type want;
      if (reset) begin
         for (int k = 0; k < TABLE_SIZE; k++) begin
            cal_table[k] = '0;
         end
         dz_enable = IGNORE_ENABLE_RESET;
         dz_width = IGNORE_DISTANCE_RESET;
         step_ms_cfg = STEP_MS_RESET;
         awaited_q.delete();
      end else begin
         if (rsp_strobe) begin
            if (awaited_q.size() == 0) begin
               $error("result seen with no item awaiting one");
               fails++;
            end else begin
               want = awaited_q.pop_front();
               check_field("direction", 32'(want.direction), 32'(rsp_direction));
               check_field("turn_time_ms", 32'(want.turn_time_ms), 32'(rsp_turn_time_ms));
               check_field("reduced_angle", 32'(want.reduced_angle),
                           32'(rsp_reduced_angle));
               check_field("turn_issued", 32'(want.turn_issued), 32'(rsp_turn_issued));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IGNORE_ENABLE:   dz_enable = csr_data[0];
               CSR_IGNORE_DISTANCE: dz_width = csr_data[ANGLE_W-1:0];
               CSR_STEP_MS:         step_ms_cfg = csr_data[STEP_W-1:0];
               default: ;
            endcase
         end
         if (req_start && !busy) begin
            if (req_action == ACT_LOAD) begin
               // Entry zero is pinned at zero, so loads aimed at it are dropped.
               if (req_entry_index != 0 && int'(req_entry_index) < TABLE_SIZE) begin
                  cal_table[req_entry_index] = ENTRY_W'(wrap_turn(
                     int'(req_heading_after) - int'(req_heading_before)));
               end
               awaited_q.push_back('0);
            end else begin
               awaited_q.push_back(predict_turn(req_target_angle));
            end
         end
      end
      pending_items <= awaited_q.size();
      fail_count <= fails;
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

// Top of the turn time regression. This module only produces stimulus and
// gives the verdict; all prediction and comparison lives in the checker that
// sits beside the block and watches its ports.
module testbench;
   import tadt_pkg::*;

   localparam int TABLE_SIZE   = TABLE_SIZE_DEFAULT;
   localparam int RANDOM_ITEMS = 1100;
   // Even the slowest run, with the longest turns and sender gaps, stays far
   // below this limit.
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 64;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_start = 1'b0;
   logic                       req_action = ACT_LOAD;
   logic [3:0]                 req_entry_index = '0;
   logic [ENTRY_W-1:0]         req_heading_before = '0;
   logic [ENTRY_W-1:0]         req_heading_after = '0;
   logic signed [TARGET_W-1:0] req_target_angle = '0;
   logic                       csr_valid = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = CSR_IGNORE_ENABLE;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   logic                       busy;
   logic                       rsp_strobe;
   logic [1:0]                 rsp_direction;
   logic [TIME_W-1:0]          rsp_turn_time_ms;
   logic [ANGLE_W-1:0]         rsp_reduced_angle;
   logic                       rsp_turn_issued;
   logic                       csr_ready;

   int pending_items;
   int fail_count;
   int cycle_count = 0;
   int items_counted = 0;
   // When set, the sender issues items back to back with no gaps at all.
   bit no_gaps = 0;
   // The dead zone width currently programmed, used to aim turns at its edge.
   int cur_dz_width = int'(IGNORE_DISTANCE_RESET);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   turn_angle_to_drive_time #(.TABLE_SIZE(TABLE_SIZE)) uut (
      .clock              (clock),
      .reset              (reset),
      .req_start          (req_start),
      .busy               (busy),
      .req_action         (req_action),
      .req_entry_index    (req_entry_index),
      .req_heading_before (req_heading_before),
      .req_heading_after  (req_heading_after),
      .req_target_angle   (req_target_angle),
      .rsp_strobe         (rsp_strobe),
      .rsp_direction      (rsp_direction),
      .rsp_turn_time_ms   (rsp_turn_time_ms),
      .rsp_reduced_angle  (rsp_reduced_angle),
      .rsp_turn_issued    (rsp_turn_issued),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   turn_time_checker #(.TABLE_SIZE(TABLE_SIZE)) turn_check (
      .clock              (clock),
      .reset              (reset),
      .req_start          (req_start),
      .busy               (busy),
      .req_action         (req_action),
      .req_entry_index    (req_entry_index),
      .req_heading_before (req_heading_before),
      .req_heading_after  (req_heading_after),
      .req_target_angle   (req_target_angle),
      .rsp_strobe         (rsp_strobe),
      .rsp_direction      (rsp_direction),
      .rsp_turn_time_ms   (rsp_turn_time_ms),
      .rsp_reduced_angle  (rsp_reduced_angle),
      .rsp_turn_issued    (rsp_turn_issued),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .pending_items      (pending_items),
      .fail_count         (fail_count)
   );

   // Hard stop in case the block hangs or never answers an item.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Idle time on the sender side after an item is taken. Most gaps are zero
   // or short; a few are long enough to let the block go fully idle.
   task automatic pause_gap();
      int pick, gap;
      gap = 0;
      if (!no_gaps) begin
         pick = $urandom_range(0, 99);
         if (pick >= 95) begin
            gap = $urandom_range(15, 80);
         end else if (pick >= 65) begin
            gap = $urandom_range(1, 4);
         end
      end
      if (gap > 0) begin
         req_start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Presents one item and holds it until the block takes it. The busy flag
   // is read right after the edge, so it still shows the value that decided
   // acceptance at that edge.
   task automatic issue_item(logic action, logic [3:0] idx, int head_before, int head_after,
                             logic signed [TARGET_W-1:0] target);
      req_action <= action;
      req_entry_index <= idx;
      req_heading_before <= ENTRY_W'(head_before);
      req_heading_after <= ENTRY_W'(head_after);
      req_target_angle <= target;
      req_start <= 1'b1;
      do @(posedge clock); while (busy);
      // A load into entry zero is dropped by the block, so it is not counted.
      if (!(action == ACT_LOAD && idx == 0)) begin
         items_counted++;
      end
      pause_gap();
   endtask

   // Turn items carry random load fields, which the block must ignore.
   task automatic issue_turn(int target);
      issue_item(ACT_TURN, 4'($urandom), $urandom_range(0, 8191), $urandom_range(0, 8191),
                 TARGET_W'(target));
   endtask

   // Loads an entry with the given heading change. The headings themselves are
   // random and may lie beyond one full turn; the after heading is folded back
   // by a full turn when it would not fit, which keeps the change the same.
   task automatic load_entry(logic [3:0] idx, int delta);
      int head_before, head_after;
      head_before = $urandom_range(0, 8191);
      head_after = head_before + delta;
      if (head_after > 8191) begin
         head_after -= FULL_TURN;
      end
      issue_item(ACT_LOAD, idx, head_before, head_after, TARGET_W'($urandom));
   endtask

   // Stops offering items and waits until every awaited result has arrived
   // and the block is idle. The first edge is always taken so that the
   // checker's count already includes an item taken in this same step.
   task automatic wait_drained();
      req_start <= 1'b0;
      do @(posedge clock); while (pending_items != 0 || busy);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Writes all three registers. Bits above the enable and step register widths
   // are random so that the block is seen to ignore them.
   task automatic set_config(logic en, int width, int step);
      write_csr(CSR_IGNORE_ENABLE, {11'($urandom), en});
      write_csr(CSR_IGNORE_DISTANCE, CSR_DATA_W'(width));
      write_csr(CSR_STEP_MS, {4'($urandom), 8'(step)});
      csr_valid <= 1'b0;
      cur_dz_width = width;
   endtask

   // Builds a calibration table. Most tables rise monotonically, which is
   // what a real calibration gives and what reaches the interpolation. Some
   // runs flatten at the top, stop part way, or are plain random noise.
   task automatic load_calibration();
      int mode, acc, top, span_max;
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
         acc = 0;
         top = (mode == 6) ? $urandom_range(1, TABLE_SIZE - 1) : TABLE_SIZE - 1;
         span_max = $urandom_range(0, 1) ? 420 : 200;
         for (int k = 1; k <= top; k++) begin
            acc += $urandom_range(0, span_max);
            if (acc > FULL_TURN - 1) begin
               acc = FULL_TURN - 1;
            end
            load_entry(4'(k), acc);
         end
      end else begin
         repeat ($urandom_range(3, 12)) begin
            issue_item(ACT_LOAD, 4'($urandom), $urandom_range(0, 8191),
                       $urandom_range(0, 8191), TARGET_W'($urandom));
         end
      end
   endtask

   // Target angles: a share is fully random, some land near the dead zone edge,
   // the half turn or whole turns, the rest anywhere; some get whole turns added on.
   function automatic int random_target();
      int pick, laps, v;
      pick = $urandom_range(0, 9);
      laps = int'($urandom_range(0, 182)) - 91;
      case (pick)
         0, 1, 2: v = int'($urandom);
         3:       v = int'($urandom_range(0, 800)) - 400;
         4:       v = HALF_TURN + int'($urandom_range(0, 16)) - 8 + laps * FULL_TURN;
         5:       v = cur_dz_width + int'($urandom_range(0, 4)) - 2
                      + ($urandom_range(0, 1) ? 0 : FULL_TURN - 2 * cur_dz_width);
         6:       v = laps * FULL_TURN + int'($urandom_range(0, 20)) - 10;
         default: v = int'($urandom_range(0, FULL_TURN - 1)) + laps * FULL_TURN;
      endcase
      return v;
   endfunction

   initial begin
      int phase;
      int turns;
      logic en;
      int width, step;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with the settings the block comes out of reset with:
      // dead zone on at 10 degrees, 50 ms per step, empty table.
      issue_turn(0);               // dead zone with no table
      issue_turn(5000);            // left turn; empty table misses every entry
      issue_turn(-524288);         // most negative target
      issue_turn(524287);          // most positive target
      issue_item(ACT_LOAD, 4'd0, 8191, 0, TARGET_W'(0));  // entry zero is fixed
      load_entry(4'd1, 300);
      issue_item(ACT_LOAD, 4'd2, 7000, 2140, TARGET_W'(0));  // wraps below zero
      issue_item(ACT_LOAD, 4'd3, 8191, 4231, TARGET_W'(0));  // heading past a full turn
      issue_item(ACT_LOAD, 4'd4, 0, 3000, TARGET_W'(-1));
      issue_turn(200);             // interpolates inside the first segment
      issue_turn(300);             // lands exactly on an entry
      issue_turn(159);             // just inside the dead zone
      issue_turn(160);             // first angle outside it
      issue_turn(2879);            // largest right turn
      issue_turn(2880);            // half turn goes left
      issue_turn(2881);
      issue_turn(-1);              // tiny left turn, dead zone
      issue_turn(-3 * FULL_TURN);  // whole turns reduce to zero
      load_entry(4'd5, 100);       // entry below its neighbor
      issue_turn(2800);
      issue_turn(-2800);

      // Random phases. Each one starts from an idle block, which is also the
      // point where the sender waits for every awaited result to come in.
      // The first few phases cover the register extremes, including a step
      // time of zero and, switched off, a dead zone wider than any reduced angle.
      phase = 0;
      while (items_counted < RANDOM_ITEMS + 20) begin
         wait_drained();
         case (phase)
            0:       set_config(1'b0, 0, 255);
            1:       set_config(1'b1, HALF_TURN, 1);
            2:       set_config(1'b1, 0, 0);
            3:       set_config(1'b0, 4095, 128);
            4:       set_config(1'b1, 1, 1);
            default: begin
               en = 1'($urandom);
               width = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                   : $urandom_range(0, 400);
               step = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 255);
               set_config(en, width, step);
            end
         endcase
         no_gaps = ($urandom_range(0, 3) == 0);
         @(posedge clock);
         load_calibration();
         turns = $urandom_range(20, 60);
         repeat (turns) begin
            case ($urandom_range(0, 19))
               // An odd load in the middle of the turns rewrites one entry unless it aims at entry zero.
               0:       issue_item(ACT_LOAD, 4'($urandom), $urandom_range(0, 8191),
                                   $urandom_range(0, 8191), TARGET_W'($urandom));
               1:       begin
                  // Let the block drain fully before the next turn.
                  wait_drained();
                  issue_turn(random_target());
               end
               default: issue_turn(random_target());
            endcase
         end
         phase++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_items == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: turn_angle_to_drive_time.f
rtl/tadt_pkg.sv
rtl/tadt_div.sv
rtl/tadt_smul.sv
rtl/tadt_table.sv
rtl/turn_angle_to_drive_time.sv
tb/turn_time_checker.sv
tb/testbench.sv
